// ----- rtl/cdq_pkg.sv -----
`default_nettype none

package cdq_pkg;

	// Element, request and status types.
	typedef logic [31:0] word_t;
	typedef logic [2:0] op_t;
	typedef logic [1:0] status_t;

	// Request codes.
	localparam op_t OP_PUSH_FRONT = 3'd0;
	localparam op_t OP_PUSH_BACK  = 3'd1;
	localparam op_t OP_POP_FRONT  = 3'd2;
	localparam op_t OP_POP_BACK   = 3'd3;
	localparam op_t OP_PEEK_FRONT = 3'd4;
	localparam op_t OP_PEEK_BACK  = 3'd5;
	localparam op_t OP_CLEAR      = 3'd6;

	// Status codes.
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	// Data returned by a pop or peek on an empty deque.
	localparam word_t UNDERFLOW_WORD = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ----- rtl/cdq_ram.sv -----
`default_nettype none

module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/circular_double_ended_queue.sv -----
// Channel   Handshake       Fields                              Direction
// request   start / busy    op, value                           in
// result    done            data, status, is_empty, is_full     out
//
// One request is taken in every cycle; busy stays low.
// The result of a request shows in the cycle after it is accepted, since the
// element memory has a registered read.
// Reset empties the deque at once; the element memory needs no clearing.
// Results cannot be stalled: done is high for a single cycle per item.
`default_nettype none

module circular_double_ended_queue #(
	parameter int DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire cdq_pkg::op_t     op,
	input  wire cdq_pkg::word_t   value,
	output logic                  done,
	output cdq_pkg::word_t        data,
	output cdq_pkg::status_t      status,
	output logic                  is_empty,
	output logic                  is_full
);

	import cdq_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [OW-1:0] OCC_FULL = OW'(DEPTH);

	logic [PW-1:0] head_q, tail_q;
	logic [OW-1:0] occ_q;

	logic [PW-1:0] head_d, tail_d;
	logic [OW-1:0] occ_d;
	logic          acc;
	logic          cur_empty, cur_full;
	logic          we, re;
	logic [PW-1:0] waddr, raddr;
	status_t       status_d;
	word_t         rdata;

	logic    done_s1, use_ram_s1, empty_s1, full_s1;
	status_t status_s1;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
		return (p == '0) ? PTR_LAST : p - PW'(1);
	endfunction

	assign busy = 1'b0;
	assign acc = start && !busy;
	assign cur_empty = (occ_q == '0);
	assign cur_full = (occ_q == OCC_FULL);

	// Decode the request against the current pointers and occupancy.
	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		occ_d = occ_q;
		status_d = ST_OK;
		we = 1'b0;
		re = 1'b0;
		waddr = '0;
		raddr = (op inside {OP_POP_FRONT, OP_PEEK_FRONT}) ? head_q : tail_q;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (cur_full) begin
					status_d = ST_OVERFLOW;
				end else begin
					we = 1'b1;
					occ_d = occ_q + OW'(1);
					if (cur_empty) begin
						head_d = '0;
						tail_d = '0;
						waddr = '0;
					end else if (op == OP_PUSH_FRONT) begin
						head_d = wrap_dec(head_q);
						waddr = head_d;
					end else begin
						tail_d = wrap_inc(tail_q);
						waddr = tail_d;
					end
				end
			end
			OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
				if (cur_empty) begin
					status_d = ST_UNDERFLOW;
				end else begin
					re = 1'b1;
					if (op inside {OP_POP_FRONT, OP_POP_BACK}) begin
						if (occ_q == OW'(1)) begin
							head_d = '0;
							tail_d = '0;
							occ_d = '0;
						end else begin
							occ_d = occ_q - OW'(1);
							if (op == OP_POP_FRONT) begin
								head_d = wrap_inc(head_q);
							end else begin
								tail_d = wrap_dec(tail_q);
							end
						end
					end
				end
			end
			OP_CLEAR: begin
				head_d = '0;
				tail_d = '0;
				occ_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Pointer and occupancy registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q <= '0;
		end else if (acc) begin
			head_q <= head_d;
			tail_q <= tail_d;
			occ_q <= occ_d;
		end
	end

	// Result stage, aligned with the memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			use_ram_s1 <= 1'b0;
			status_s1 <= ST_OK;
			empty_s1 <= 1'b1;
			full_s1 <= 1'b0;
		end else begin
			done_s1 <= acc;
			if (acc) begin
				use_ram_s1 <= re;
				status_s1 <= status_d;
				empty_s1 <= (occ_d == '0);
				full_s1 <= (occ_d == OCC_FULL);
			end
		end
	end

	// Element memory.
	cdq_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (acc && we),
		.waddr(waddr),
		.wdata(value),
		.re   (acc && re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Result outputs.
	assign done = done_s1;
	assign status = status_s1;
	assign is_empty = empty_s1;
	assign is_full = full_s1;
	assign data = use_ram_s1 ? rdata :
		((status_s1 == ST_UNDERFLOW) ? UNDERFLOW_WORD : '0);

endmodule

`default_nettype wire

// ----- rtl/cdq_checker.sv -----
`default_nettype none

module cdq_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire cdq_pkg::op_t     op,
	input wire logic             done,
	input wire cdq_pkg::word_t   data,
	input wire cdq_pkg::status_t status,
	input wire logic             is_empty,
	input wire logic             is_full
);

	import cdq_pkg::*;

	// Every result belongs to an item accepted in the cycle before.
	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without an accepted item");

	// The deque is never empty and full at once.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_empty && is_full))
		else $error("empty and full together");

	// An underflow reports the all-ones word and an empty deque.
	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_UNDERFLOW) |-> (data == UNDERFLOW_WORD && is_empty))
		else $error("bad underflow result");

	// An overflow leaves the deque full and returns zero.
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_OVERFLOW) |-> (is_full && data == '0))
		else $error("bad overflow result");

	// A clear empties the deque.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_CLEAR) |=> (done && is_empty && status == ST_OK))
		else $error("clear did not empty the deque");

endmodule

bind circular_double_ended_queue cdq_checker u_cdq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.op      (op),
	.done    (done),
	.data    (data),
	.status  (status),
	.is_empty(is_empty),
	.is_full (is_full)
);

`default_nettype wire

// ----- dv/circular_double_ended_queue_tb.sv -----
`default_nettype none

module circular_double_ended_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 950;

	// The op code that the block takes but does nothing with.
	localparam op_t OP_UNUSED = 3'd7;

	// Expected contents of one result.
	typedef struct {
		word_t   data;
		status_t status;
		logic    empty;
		logic    full;
	} outcome_t;

	// Tracks the deque contents and the results still owed by the block.
	class deque_scoreboard;
		word_t    slots[DEPTH];
		int       head_ptr;
		int       tail_ptr;
		int       fill;
		outcome_t owed[$];
		int       mismatches;

		function new();
			head_ptr = 0;
			tail_ptr = 0;
			fill = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// Applies one accepted request to the deque and records its result.
		function void note_request(op_t req, word_t val);
			outcome_t o;
			int       idx;
			o.data = '0;
			o.status = ST_OK;
			case (req)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (fill == DEPTH) begin
						o.status = ST_OVERFLOW;
					end else begin
						if (fill == 0) begin
							head_ptr = 0;
							tail_ptr = 0;
							slots[0] = val;
						end else if (req == OP_PUSH_FRONT) begin
							head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
							slots[head_ptr] = val;
						end else begin
							tail_ptr = (tail_ptr + 1) % DEPTH;
							slots[tail_ptr] = val;
						end
						fill++;
					end
				end
				OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
					if (fill == 0) begin
						o.status = ST_UNDERFLOW;
						o.data = UNDERFLOW_WORD;
					end else begin
						idx = (req == OP_POP_FRONT || req == OP_PEEK_FRONT) ?
							head_ptr : tail_ptr;
						o.data = slots[idx];
						if (req == OP_POP_FRONT || req == OP_POP_BACK) begin
							// Taking the last element brings both pointers home.
							if (fill == 1) begin
								head_ptr = 0;
								tail_ptr = 0;
							end else if (req == OP_POP_FRONT) begin
								head_ptr = (head_ptr + 1) % DEPTH;
							end else begin
								tail_ptr = (tail_ptr + DEPTH - 1) % DEPTH;
							end
							fill--;
						end
					end
				end
				OP_CLEAR: begin
					head_ptr = 0;
					tail_ptr = 0;
					fill = 0;
				end
				default: begin
				end
			endcase
			o.empty = (fill == 0);
			o.full = (fill == DEPTH);
			owed.push_back(o);
		endfunction

		// Compares one result with the oldest expectation.
		function void check_result(word_t d, status_t s, logic e, logic f);
			outcome_t o;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: data %h status %0d empty %b full %b",
						d, s, e, f);
				return;
			end
			o = owed.pop_front();
			if (d !== o.data || s !== o.status || e !== o.empty || f !== o.full) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result mismatch: expected data %h status %0d empty %b full %b,",
						" got data %h status %0d empty %b full %b"},
						o.data, o.status, o.empty, o.full, d, s, e, f);
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	op_t     op;
	word_t   value;
	logic    done;
	word_t   data;
	status_t status;
	logic    is_empty;
	logic    is_full;

	deque_scoreboard sb = new();

	int  sent;
	bit  quiet;

	circular_double_ended_queue #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.value(value),
		.done(done),
		.data(data),
		.status(status),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Results are checked before the item accepted at the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(data, status, is_empty, is_full);
			if (start && !busy)
				sb.note_request(op, value);
		end
	end

	// Offers one item, with an occasional random gap in front of it.
	task automatic send_request(op_t req, word_t val);
		int gap;
		if (!quiet && $urandom_range(0, 99) < 4) begin
			gap = $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		op <= req;
		value <= val;
		do
			@(posedge clk);
		while (busy);
		sent++;
		quiet = (sent >= 400 && sent < 600);
	endtask

	// Picks an op: a push with the given chance in percent, else mostly reads.
	function automatic op_t pick_op(int push_pct);
		int r;
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		r = $urandom_range(0, 99);
		if (r < 2)
			return OP_CLEAR;
		if (r < 4)
			return OP_UNUSED;
		return op_t'(OP_POP_FRONT + $urandom_range(0, 3));
	endfunction

	// Stimulus: a directed opening, then bursts that fill, drain and mix, with an occasional clear.
	initial begin
		int burst;
		int mode;
		int push_pct;
		start = 1'b0;
		op = OP_CLEAR;
		value = '0;
		arst_n = 1'b0;
		sent = 0;
		quiet = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reads on an empty deque underflow, then the unused op is sent.
		send_request(OP_POP_FRONT, 32'h1234_5678);
		send_request(OP_POP_BACK, '0);
		send_request(OP_PEEK_FRONT, '0);
		send_request(OP_PEEK_BACK, '1);
		send_request(OP_UNUSED, 32'hDEAD_BEEF);
		// Pushes at both ends with extreme values, then reads them back.
		send_request(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_request(OP_PUSH_BACK, 32'h8000_0000);
		send_request(OP_PUSH_FRONT, 32'h0000_0000);
		send_request(OP_PUSH_BACK, 32'hFFFF_FFFF);
		send_request(OP_PEEK_FRONT, '0);
		send_request(OP_PEEK_BACK, '0);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_PEEK_BACK, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_BACK, '0);
		// Clear on an empty and on a non-empty deque.
		send_request(OP_CLEAR, 32'h5555_5555);
		send_request(OP_PUSH_BACK, 32'hAAAA_AAAA);
		send_request(OP_CLEAR, '0);
		send_request(OP_PEEK_FRONT, '0);

		// Random bursts until enough items have gone in.
		while (sent < RANDOM_ITEMS + 21) begin
			mode = $urandom_range(0, 9);
			burst = $urandom_range(8, 40);
			if (mode < 3)
				push_pct = 85;
			else if (mode < 6)
				push_pct = 15;
			else if (mode < 9)
				push_pct = 50;
			else
				burst = 0;
			if (burst == 0)
				send_request(OP_CLEAR, $urandom());
			repeat (burst)
				send_request(pick_op(push_pct), $urandom());
		end

		@(negedge clk);
		start <= 1'b0;

		// Drain the results, then wait on for any stray ones.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_double_ended_queue.sv
rtl/cdq_checker.sv
dv/circular_double_ended_queue_tb.sv
